/* rtl/core/atmd_pkg.sv */
package atmd_pkg;

  // Sample width and configuration register width.
  localparam int SAMPLE_W = 14;
  localparam int CFG_W    = 14;

  // APB port geometry.
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  // Register index, taken from address bit 2.
  localparam logic REG_TAP_DELTA    = 1'b0;
  localparam logic REG_MOTION_RANGE = 1'b1;

  // Register reset values.
  localparam logic [CFG_W-1:0] TAP_DELTA_RESET    = CFG_W'(300);
  localparam logic [CFG_W-1:0] MOTION_RANGE_RESET = CFG_W'(50);

  // Per-axis control: update with a valid sample, first valid sample of the
  // batch, and clear at the end of the batch.
  typedef struct packed {
    logic upd;
    logic first;
    logic clr;
  } atmd_ctl_t;

endpackage

/* rtl/core/atmd_in_if.sv */
interface atmd_in_if #(
  parameter int SAMPLE_WIDTH = atmd_pkg::SAMPLE_W
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] accel_x;
  logic signed [SAMPLE_WIDTH-1:0] accel_y;
  logic signed [SAMPLE_WIDTH-1:0] accel_z;
  logic                           vibrating;
  logic                           batch_end;

  modport source (output valid, accel_x, accel_y, accel_z, vibrating, batch_end,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, vibrating, batch_end,
                  output ready);
endinterface

/* rtl/core/atmd_out_if.sv */
interface atmd_out_if;
  logic valid;
  logic ready;
  logic motion_seen;
  logic tap_seen;

  modport source (output valid, motion_seen, tap_seen, input ready);
  modport sink   (input valid, motion_seen, tap_seen, output ready);
endinterface

/* rtl/core/atmd_cfg_regs.sv */
module atmd_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [atmd_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [atmd_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [atmd_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  output logic [atmd_pkg::CFG_W-1:0]   tap_thr,
  output logic [atmd_pkg::CFG_W-1:0]   motion_thr
);
  import atmd_pkg::*;

  logic             wr_en;
  logic [CFG_W-1:0] tap_thr_r;
  logic [CFG_W-1:0] motion_thr_r;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_thr_r    <= TAP_DELTA_RESET;
      motion_thr_r <= MOTION_RANGE_RESET;
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        REG_TAP_DELTA:    tap_thr_r    <= cfg_pwdata[CFG_W-1:0];
        REG_MOTION_RANGE: motion_thr_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (cfg_paddr[2])
      REG_TAP_DELTA:    cfg_prdata = APB_DW'(tap_thr_r);
      REG_MOTION_RANGE: cfg_prdata = APB_DW'(motion_thr_r);
      default:          cfg_prdata = '0;
    endcase
  end

  assign tap_thr    = tap_thr_r;
  assign motion_thr = motion_thr_r;

endmodule

/* rtl/core/atmd_axis.sv */
module atmd_axis #(
  parameter int SAMPLE_WIDTH = atmd_pkg::SAMPLE_W
) (
  input  logic                           clk,
  input  atmd_pkg::atmd_ctl_t            ctl,
  input  logic                           have_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic [atmd_pkg::CFG_W-1:0]     tap_thr,
  input  logic [atmd_pkg::CFG_W-1:0]     motion_thr,
  output logic                           tap_hit,
  output logic                           motion_hit
);
  import atmd_pkg::*;

  localparam int EW = SAMPLE_WIDTH + 1;
  localparam int DW = (EW > CFG_W) ? EW : CFG_W;

  logic signed [SAMPLE_WIDTH-1:0] min_r, max_r, prev_r;
  logic signed [SAMPLE_WIDTH-1:0] min_nxt, max_nxt;
  logic signed [EW-1:0]           delta;
  logic        [EW-1:0]           mag;
  logic signed [EW-1:0]           range_s;

  // Absolute change against the previous valid sample, at full precision.
  assign delta   = EW'(sample) - EW'(prev_r);
  assign mag     = delta[EW-1] ? EW'(-delta) : EW'(delta);
  assign tap_hit = ctl.upd && have_valid && (DW'(mag) > DW'(tap_thr));

  // Running extremes including the current sample.
  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (ctl.upd) begin
      if (ctl.first || (sample < min_r)) min_nxt = sample;
      if (ctl.first || (sample > max_r)) max_nxt = sample;
    end
  end

  // Range is never negative; an empty batch leaves both extremes at zero.
  assign range_s    = EW'(max_nxt) - EW'(min_nxt);
  assign motion_hit = DW'(unsigned'(range_s)) > DW'(motion_thr);

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      min_r  <= '0;
      max_r  <= '0;
      prev_r <= '0;
    end else if (ctl.upd) begin
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      prev_r <= sample;
    end
  end

endmodule

/* rtl/core/accel_tap_motion_detector.sv */
// Tap and motion detector for a three-axis accelerometer stream. Each beat on
// in_ch carries one sample; samples flagged as vibrating are ignored. Over the
// valid samples of a batch the block keeps per-axis minimum, maximum and the
// last sample, latches a tap when any axis moves by more than the tap delta
// threshold between consecutive valid samples, and on the beat marked
// batch_end delivers one beat on out_ch with motion_seen (some axis range above
// the motion range threshold) and tap_seen. A new sample is taken every cycle
// unless in_ch stalls. A batch_end beat is caught in an input register and then
// moves into the result register, which raises out_ch.valid. in_ch stalls only
// when a batch_end sample sits in the input register while the previous result
// is still not taken. The user must write the thresholds through the APB port
// (tap delta at 0x0, motion range at 0x4) only while the block is idle; the
// block does not enforce this. Both reset to 300 and 50.
module accel_tap_motion_detector #(
  parameter int SAMPLE_WIDTH = atmd_pkg::SAMPLE_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  atmd_in_if.sink                      in_ch,
  atmd_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [atmd_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [atmd_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [atmd_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import atmd_pkg::*;

  logic [CFG_W-1:0] tap_thr, motion_thr;

  // Input register.
  logic                           s1_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_smp_r [3];
  logic                           s1_vib_r;
  logic                           s1_end_r;
  logic                           s1_go;
  logic                           in_take;

  // Batch state and result register.
  logic      have_valid_r, tap_latched_r;
  logic      out_valid_r, motion_r, tap_r;
  atmd_ctl_t ctl;
  logic [2:0] tap_hit, motion_hit;
  logic      have_any;

  atmd_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .tap_thr    (tap_thr),
    .motion_thr (motion_thr)
  );

  // The held beat moves on unless it closes a batch and the result is busy.
  assign s1_go       = s1_valid_r && (!s1_end_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_smp_r[0] <= in_ch.accel_x;
      s1_smp_r[1] <= in_ch.accel_y;
      s1_smp_r[2] <= in_ch.accel_z;
      s1_vib_r    <= in_ch.vibrating;
      s1_end_r    <= in_ch.batch_end;
    end
  end

  // Per-axis control derived from the held beat.
  assign ctl.upd   = s1_go && !s1_vib_r;
  assign ctl.first = !have_valid_r;
  assign ctl.clr   = !rst_n || (s1_go && s1_end_r);

  for (genvar a = 0; a < 3; a++) begin : g_axis
    atmd_axis #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_axis (
      .clk       (clk),
      .ctl       (ctl),
      .have_valid(have_valid_r),
      .sample    (s1_smp_r[a]),
      .tap_thr   (tap_thr),
      .motion_thr(motion_thr),
      .tap_hit   (tap_hit[a]),
      .motion_hit(motion_hit[a])
    );
  end

  assign have_any = have_valid_r || ctl.upd;

  // Batch flags.
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      have_valid_r  <= 1'b0;
      tap_latched_r <= 1'b0;
    end else if (ctl.upd) begin
      have_valid_r  <= 1'b1;
      tap_latched_r <= tap_latched_r || (|tap_hit);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_end_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_end_r) begin
      motion_r <= have_any && (|motion_hit);
      tap_r    <= have_any && (tap_latched_r || (|tap_hit));
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.motion_seen = motion_r;
  assign out_ch.tap_seen    = tap_r;

endmodule

/* rtl/core/atmd_checker.sv */
module atmd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_motion_seen,
  input logic                         out_tap_seen,
  input logic                         cfg_psel,
  input logic                         cfg_penable,
  input logic                         cfg_pwrite,
  input logic [atmd_pkg::APB_AW-1:0]  cfg_paddr,
  input logic [atmd_pkg::APB_DW-1:0]  cfg_pwdata,
  input logic [atmd_pkg::APB_DW-1:0]  cfg_prdata
);
  import atmd_pkg::*;

  // A result beat holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_motion_seen) &&
                                $stable(out_tap_seen))
    else $error("result beat changed while stalled");

  // With the result register empty, the input side never stalls.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

  // A tap threshold write reads back on the next cycle.
  a_tap_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_TAP_DELTA)
    |=> (cfg_paddr[2] != REG_TAP_DELTA) ||
        (cfg_prdata[CFG_W-1:0] == $past(cfg_pwdata[CFG_W-1:0])))
    else $error("tap threshold readback mismatch");

  // Unused register bits read as zero.
  a_prdata_upper: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_prdata[APB_DW-1:CFG_W] == '0)
    else $error("upper register bits not zero");

endmodule

bind accel_tap_motion_detector atmd_checker u_atmd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_motion_seen(out_ch.motion_seen),
  .out_tap_seen   (out_ch.tap_seen),
  .cfg_psel       (cfg_psel),
  .cfg_penable    (cfg_penable),
  .cfg_pwrite     (cfg_pwrite),
  .cfg_paddr      (cfg_paddr),
  .cfg_pwdata     (cfg_pwdata),
  .cfg_prdata     (cfg_prdata)
);

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import atmd_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASES          = 9;
  localparam int PHASE_ITEMS     = 190;

  // One input beat as the sender sees it.
  typedef struct {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
    logic                       vibrating;
    logic                       batch_end;
  } accel_sample_t;

  // One result beat: the two batch flags.
  typedef struct {
    logic motion;
    logic tap;
  } flag_pair_t;

  // Tracks batch state from accepted samples and compares result beats.
  class detector_scoreboard;
    logic [CFG_W-1:0]           tap_limit;
    logic [CFG_W-1:0]           motion_limit;
    bit                         seen_valid;
    bit                         tap_hit;
    logic signed [SAMPLE_W-1:0] axis_lo [3];
    logic signed [SAMPLE_W-1:0] axis_hi [3];
    logic signed [SAMPLE_W-1:0] prior [3];
    flag_pair_t                 flags_due [$];
    int failures;
    int results_checked;
    int samples_taken;
    int motion_hits;
    int tap_hits;
    int settings_used;

    function new();
      tap_limit       = TAP_DELTA_RESET;
      motion_limit    = MOTION_RANGE_RESET;
      failures        = 0;
      results_checked = 0;
      samples_taken   = 0;
      motion_hits     = 0;
      tap_hits        = 0;
      settings_used   = 1;
      clear_batch();
    endfunction

    function void clear_batch();
      seen_valid = 1'b0;
      tap_hit    = 1'b0;
      for (int k = 0; k < 3; k++) begin
        axis_lo[k] = '0;
        axis_hi[k] = '0;
        prior[k]   = '0;
      end
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    function void set_threshold(logic reg_idx, logic [CFG_W-1:0] value);
      if (reg_idx == REG_TAP_DELTA) tap_limit = value;
      else motion_limit = value;
    endfunction

    function void compare_register(logic reg_idx, logic [CFG_W-1:0] got);
      logic [CFG_W-1:0] want;
      want = (reg_idx == REG_TAP_DELTA) ? tap_limit : motion_limit;
      if (got !== want)
        note_failure($sformatf("register %0d read %0d, expected %0d", reg_idx, got, want));
    endfunction

    // Updates the batch state with one accepted sample; a batch end yields flags.
    function void note_sample(accel_sample_t s);
      logic signed [SAMPLE_W-1:0] v [3];
      int delta;
      flag_pair_t res;
      v[0] = s.x;
      v[1] = s.y;
      v[2] = s.z;
      samples_taken++;
      if (!s.vibrating) begin
        for (int k = 0; k < 3; k++) begin
          if (!seen_valid) begin
            axis_lo[k] = v[k];
            axis_hi[k] = v[k];
          end else begin
            // Full-precision change from the previous valid sample.
            delta = int'(v[k]) - int'(prior[k]);
            if (delta < 0) delta = -delta;
            if (delta > int'(tap_limit)) tap_hit = 1'b1;
            if (v[k] < axis_lo[k]) axis_lo[k] = v[k];
            if (v[k] > axis_hi[k]) axis_hi[k] = v[k];
          end
          prior[k] = v[k];
        end
        seen_valid = 1'b1;
      end
      if (s.batch_end) begin
        res.motion = 1'b0;
        for (int k = 0; k < 3; k++) begin
          if (seen_valid && (int'(axis_hi[k]) - int'(axis_lo[k]) > int'(motion_limit)))
            res.motion = 1'b1;
        end
        res.tap = seen_valid && tap_hit;
        flags_due.push_back(res);
        clear_batch();
      end
    endfunction

    function void check_result(logic motion, logic tap);
      flag_pair_t want;
      if (flags_due.size() == 0) begin
        note_failure($sformatf("result motion=%b tap=%b with nothing outstanding", motion, tap));
        return;
      end
      want = flags_due.pop_front();
      results_checked++;
      if (want.motion) motion_hits++;
      if (want.tap) tap_hits++;
      if (motion !== want.motion)
        note_failure($sformatf("motion_seen got %b, expected %b", motion, want.motion));
      if (tap !== want.tap)
        note_failure($sformatf("tap_seen got %b, expected %b", tap, want.tap));
    endfunction

    function int pending();
      return flags_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  atmd_in_if  in_bus ();
  atmd_out_if out_bus ();

  detector_scoreboard board;

  // Idle controls for the sender and the receiver.
  bit src_steady   = 1'b0;
  bit sink_steady  = 1'b0;
  bit hold_off_req = 1'b0;

  accel_tap_motion_detector u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Moves one axis by a bounded random step, clamped to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] drift(logic signed [SAMPLE_W-1:0] cur,
                                                      int spread);
    int v;
    v = int'(cur) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 8191) v = 8191;
    if (v < -8192) v = -8192;
    return SAMPLE_W'(v);
  endfunction

  function automatic logic [CFG_W-1:0] random_threshold();
    if ($urandom_range(0, 99) < 15) return CFG_W'($urandom_range(0, 16383));
    return CFG_W'($urandom_range(0, 700));
  endfunction

  // Offers one beat until it is taken, then idles for a random gap.
  task automatic offer_sample(accel_sample_t s);
    int gap;
    in_bus.valid     <= 1'b1;
    in_bus.accel_x   <= s.x;
    in_bus.accel_y   <= s.y;
    in_bus.accel_z   <= s.z;
    in_bus.vibrating <= s.vibrating;
    in_bus.batch_end <= s.batch_end;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    board.note_sample(s);
    gap = pick_gap(src_steady);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic offer_fields(int x, int y, int z, bit vib, bit last_one);
    accel_sample_t s;
    s.x         = SAMPLE_W'(x);
    s.y         = SAMPLE_W'(y);
    s.z         = SAMPLE_W'(z);
    s.vibrating = vib;
    s.batch_end = last_one;
    offer_sample(s);
  endtask

  // Stops offering and waits until every batch result has come back.
  task automatic wait_results_done();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Back-to-back APB transfers keep psel high; cfg_release ends the group.
  task automatic cfg_write(logic reg_idx, logic [CFG_W-1:0] value);
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= APB_DW'(value);
    cfg_pwrite  <= 1'b1;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    board.set_threshold(reg_idx, value);
  endtask

  task automatic cfg_check(logic reg_idx);
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwrite  <= 1'b0;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    board.compare_register(reg_idx, cfg_prdata[CFG_W-1:0]);
  endtask

  task automatic cfg_release();
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Hand-picked batches at the default thresholds.
  task automatic run_directed();
    // Batch with only a vibrating sample: nothing valid.
    offer_fields(5, 5, 5, 1'b1, 1'b1);
    // Single valid sample at the field extremes.
    offer_fields(-8192, 8191, 0, 1'b0, 1'b1);
    // Full-scale swing on every axis: no wrap in the difference.
    offer_fields(-8192, -8192, -8192, 1'b0, 1'b0);
    offer_fields(8191, 8191, 8191, 1'b0, 1'b1);
    // Change exactly at the tap threshold, range above the motion threshold.
    offer_fields(0, 0, 0, 1'b0, 1'b0);
    offer_fields(300, 0, 0, 1'b0, 1'b1);
    // Range exactly at the motion threshold.
    offer_fields(0, 0, 0, 1'b0, 1'b0);
    offer_fields(0, 50, 0, 1'b0, 1'b1);
    // Negative step just above the tap threshold.
    offer_fields(0, 0, 0, 1'b0, 1'b0);
    offer_fields(0, 0, -301, 1'b0, 1'b1);
    // Vibrating sample in the middle is skipped.
    offer_fields(100, 100, 100, 1'b0, 1'b0);
    offer_fields(8000, -8000, 8000, 1'b1, 1'b0);
    offer_fields(110, 90, 100, 1'b0, 1'b1);
    // Vibrating last sample still closes the batch.
    offer_fields(0, 0, 0, 1'b0, 1'b0);
    offer_fields(0, 0, 51, 1'b0, 1'b0);
    offer_fields(-5000, 5000, 1, 1'b1, 1'b1);
    // State cleared by the batch end: no pair with the previous batch.
    offer_fields(8000, 8000, 8000, 1'b0, 1'b1);
    // All-vibrating batch at the extremes.
    offer_fields(8191, -8192, 8191, 1'b1, 1'b0);
    offer_fields(-8192, 8191, -8192, 1'b1, 1'b1);
  endtask

  // Random batches: mostly random walks of varied step size, some noise.
  task automatic run_batches(int budget);
    int counted;
    int len;
    int spread;
    int style;
    logic signed [SAMPLE_W-1:0] pos [3];
    accel_sample_t s;
    counted = 0;
    while (counted < budget) begin
      style = $urandom_range(0, 99);
      len = $urandom_range(0, 99);
      if (len < 70) len = $urandom_range(1, 6);
      else if (len < 92) len = $urandom_range(7, 16);
      else len = $urandom_range(17, 40);
      case ($urandom_range(0, 5))
        0: spread = 3;
        1: spread = 40;
        2: spread = 200;
        3: spread = 600;
        4: spread = 4000;
        default: spread = int'(board.tap_limit) / 2 + 20;
      endcase
      foreach (pos[k]) pos[k] = SAMPLE_W'($urandom);
      for (int i = 0; i < len; i++) begin
        foreach (pos[k]) pos[k] = (style < 6) ? SAMPLE_W'($urandom) : drift(pos[k], spread);
        s.x         = pos[0];
        s.y         = pos[1];
        s.z         = pos[2];
        s.vibrating = (style >= 94) || ($urandom_range(0, 99) < 12);
        s.batch_end = (i == len - 1);
        offer_sample(s);
        counted++;
      end
    end
  endtask

  // Result side: check every accepted beat and stall at random.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready)
        board.check_result(out_bus.motion_seen, out_bus.tap_seen);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap(sink_steady);
      end
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, directed batches, then phases of random batches.
  initial begin : stimulus
    logic [CFG_W-1:0] tap_set;
    logic [CFG_W-1:0] motion_set;
    board = new();
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.accel_x   <= '0;
    in_bus.accel_y   <= '0;
    in_bus.accel_z   <= '0;
    in_bus.vibrating <= 1'b0;
    in_bus.batch_end <= 1'b0;
    cfg_psel         <= 1'b0;
    cfg_penable      <= 1'b0;
    cfg_pwrite       <= 1'b0;
    cfg_paddr        <= '0;
    cfg_pwdata       <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values of both thresholds.
    cfg_check(REG_TAP_DELTA);
    cfg_check(REG_MOTION_RANGE);
    cfg_release();

    run_directed();

    for (int p = 0; p < PHASES; p++) begin
      wait_results_done();
      case (p)
        0: begin tap_set = '0; motion_set = '0; end
        1: begin tap_set = '1; motion_set = '1; end
        2: begin tap_set = '1; motion_set = '0; end
        3: begin tap_set = '0; motion_set = '1; end
        default: begin tap_set = random_threshold(); motion_set = random_threshold(); end
      endcase
      cfg_write(REG_TAP_DELTA, tap_set);
      cfg_write(REG_MOTION_RANGE, motion_set);
      cfg_check(REG_TAP_DELTA);
      cfg_check(REG_MOTION_RANGE);
      cfg_release();
      board.settings_used++;

      // One phase runs with no idling on either side.
      src_steady  = (p == 5);
      sink_steady = (p == 5);

      // Long receiver hold-off while one-sample batches keep coming.
      if (p == 6) begin
        src_steady   = 1'b1;
        hold_off_req = 1'b1;
        repeat (40) begin
          offer_fields(int'($urandom_range(0, 16383)) - 8192,
                       int'($urandom_range(0, 16383)) - 8192,
                       int'($urandom_range(0, 16383)) - 8192, 1'b0, 1'b1);
        end
        src_steady = 1'b0;
        wait_results_done();
      end

      run_batches(PHASE_ITEMS);
      src_steady  = 1'b0;
      sink_steady = 1'b0;
    end

    wait_results_done();
    repeat (10) @(posedge clk);
    if (board.pending() != 0)
      board.note_failure($sformatf("%0d batch results never arrived", board.pending()));

    $display("Covered %0d samples and %0d batch results under %0d threshold settings.",
             board.samples_taken, board.results_checked, board.settings_used);
    $display("Motion flagged in %0d batches, tap in %0d; %0d mismatches.",
             board.motion_hits, board.tap_hits, board.failures);
    if (board.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/atmd_pkg.sv
rtl/core/atmd_in_if.sv
rtl/core/atmd_out_if.sv
rtl/core/atmd_cfg_regs.sv
rtl/core/atmd_axis.sv
rtl/core/accel_tap_motion_detector.sv
rtl/core/atmd_checker.sv
dv/testbench.sv
